// ===== sv/dwcd_pkg.sv =====
package dwcd_pkg;

  // token kinds
  localparam logic [1:0] KIND_OPEN = 2'd0;
  localparam logic [1:0] KIND_CONT = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_CMD  = 2'd3;

  // special bytes
  localparam logic [7:0] B_NUL = 8'h00;
  localparam logic [7:0] B_DEL = 8'h7F;
  localparam logic [7:0] B_ESC = 8'h1B;
  localparam logic [7:0] B_FF  = 8'h0C;
  localparam logic [7:0] B_CR  = 8'h0D;
  localparam logic [7:0] B_LF  = 8'h0A;
  localparam logic [7:0] B_BS  = 8'h08;
  localparam logic [7:0] B_US  = 8'h1F;
  localparam logic [7:0] B_RS  = 8'h1E;
  localparam logic [7:0] B_HT  = 8'h09;
  localparam logic [7:0] B_VT  = 8'h0B;
  localparam logic [7:0] B_DC1 = 8'h11;
  localparam logic [7:0] B_SO  = 8'h0E;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_SYN = 8'h16;
  localparam logic [7:0] B_GS  = 8'h1D;
  localparam logic [7:0] B_P   = 8'h50;
  localparam logic [7:0] B_SPACE = 8'h20;
  localparam logic [7:0] WHEEL_A2 = 8'hA2;
  localparam logic [7:0] WHEEL_A9 = 8'hA9;

  // command codes
  localparam logic [5:0] CMD_FORM_FEED      = 6'd0;
  localparam logic [5:0] CMD_BEGIN_LINE     = 6'd1;
  localparam logic [5:0] CMD_LINE_FEED      = 6'd2;
  localparam logic [5:0] CMD_BACKSPACE      = 6'd3;
  localparam logic [5:0] CMD_TOP_MARGIN     = 6'd4;
  localparam logic [5:0] CMD_BOTTOM_MARGIN  = 6'd5;
  localparam logic [5:0] CMD_CLEAR_TB       = 6'd6;
  localparam logic [5:0] CMD_LEFT_MARGIN    = 6'd7;
  localparam logic [5:0] CMD_RIGHT_MARGIN   = 6'd8;
  localparam logic [5:0] CMD_HALF_LF        = 6'd9;
  localparam logic [5:0] CMD_REV_HALF_LF    = 6'd10;
  localparam logic [5:0] CMD_REV_LF         = 6'd11;
  localparam logic [5:0] CMD_SEC_COLOR      = 6'd12;
  localparam logic [5:0] CMD_PRI_COLOR      = 6'd13;
  localparam logic [5:0] CMD_BOLD_ON        = 6'd14;
  localparam logic [5:0] CMD_SHADOW_ON      = 6'd15;
  localparam logic [5:0] CMD_CANCEL_WP      = 6'd16;
  localparam logic [5:0] CMD_CANCEL_BOLD    = 6'd17;
  localparam logic [5:0] CMD_AUTO_CENTER    = 6'd18;
  localparam logic [5:0] CMD_AUTO_JUSTIFY   = 6'd19;
  localparam logic [5:0] CMD_UL_ON          = 6'd20;
  localparam logic [5:0] CMD_UL_OFF         = 6'd21;
  localparam logic [5:0] CMD_FWD_PRINT      = 6'd22;
  localparam logic [5:0] CMD_BWD_PRINT      = 6'd23;
  localparam logic [5:0] CMD_HTAB_SET       = 6'd24;
  localparam logic [5:0] CMD_HTAB_CLEAR     = 6'd25;
  localparam logic [5:0] CMD_VTAB_SET       = 6'd26;
  localparam logic [5:0] CMD_CLEAR_TABS     = 6'd27;
  localparam logic [5:0] CMD_RESET_HMI      = 6'd28;
  localparam logic [5:0] CMD_MICRO_BS       = 6'd29;
  localparam logic [5:0] CMD_WHEEL_A2       = 6'd30;
  localparam logic [5:0] CMD_WHEEL_A9       = 6'd31;
  localparam logic [5:0] CMD_PRINT_SUPPRESS = 6'd32;
  localparam logic [5:0] CMD_ABS_HTAB       = 6'd33;
  localparam logic [5:0] CMD_ABS_VTAB       = 6'd34;
  localparam logic [5:0] CMD_SET_HMI        = 6'd35;
  localparam logic [5:0] CMD_SET_VMI        = 6'd36;
  localparam logic [5:0] CMD_REMOTE_RESET   = 6'd37;

  // token buffer
  localparam int BUF_DEPTH = 4;
  localparam int CNT_W     = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] code;
    logic [7:0] value;
    logic       last;
  } tok_t;

  // up to two tokens handed to the buffer per byte
  typedef struct packed {
    logic [1:0] n;
    tok_t       tok0;
    tok_t       tok1;
  } push_t;

  function automatic logic is_selector(input logic [7:0] b);
    logic hit;
    unique case (b)
      B_FF, B_US, B_HT, B_RS, B_VT, B_DC1, B_SO, B_CR, B_CAN, B_SYN, B_GS: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // {hit, code} for ESC followed by one byte
  function automatic logic [6:0] esc_code(input logic [7:0] b);
    logic [6:0] r;
    unique case (b)
      8'h54:   r = {1'b1, CMD_TOP_MARGIN};
      8'h4C:   r = {1'b1, CMD_BOTTOM_MARGIN};
      8'h43:   r = {1'b1, CMD_CLEAR_TB};
      8'h39:   r = {1'b1, CMD_LEFT_MARGIN};
      8'h30:   r = {1'b1, CMD_RIGHT_MARGIN};
      8'h55:   r = {1'b1, CMD_HALF_LF};
      8'h44:   r = {1'b1, CMD_REV_HALF_LF};
      B_LF:    r = {1'b1, CMD_REV_LF};
      8'h41:   r = {1'b1, CMD_SEC_COLOR};
      8'h42:   r = {1'b1, CMD_PRI_COLOR};
      8'h4F:   r = {1'b1, CMD_BOLD_ON};
      8'h57:   r = {1'b1, CMD_SHADOW_ON};
      8'h58:   r = {1'b1, CMD_CANCEL_WP};
      8'h26:   r = {1'b1, CMD_CANCEL_BOLD};
      8'h3D:   r = {1'b1, CMD_AUTO_CENTER};
      8'h4D:   r = {1'b1, CMD_AUTO_JUSTIFY};
      8'h45:   r = {1'b1, CMD_UL_ON};
      8'h52:   r = {1'b1, CMD_UL_OFF};
      8'h35:   r = {1'b1, CMD_FWD_PRINT};
      8'h36:   r = {1'b1, CMD_BWD_PRINT};
      8'h31:   r = {1'b1, CMD_HTAB_SET};
      8'h38:   r = {1'b1, CMD_HTAB_CLEAR};
      8'h2D:   r = {1'b1, CMD_VTAB_SET};
      8'h32:   r = {1'b1, CMD_CLEAR_TABS};
      8'h53:   r = {1'b1, CMD_RESET_HMI};
      B_BS:    r = {1'b1, CMD_MICRO_BS};
      8'h59:   r = {1'b1, CMD_WHEEL_A2};
      8'h5A:   r = {1'b1, CMD_WHEEL_A9};
      8'h37:   r = {1'b1, CMD_PRINT_SUPPRESS};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/dwcd_parser.sv =====
module dwcd_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     byte_in,
  input  logic           consume,
  input  logic           suppress_ff,
  output dwcd_pkg::push_t push
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ESC, ST_ARG} pstate_t;

  pstate_t    state_r, state_nxt;
  logic [7:0] sel_r, sel_nxt;
  logic       ff_pending_r, ff_pending_nxt;

  // control byte handling
  logic           ctl_has;
  dwcd_pkg::tok_t ctl_tok;
  pstate_t        ctl_state;
  logic           ctl_ff_pending;

  logic [6:0]     esc;
  logic [1:0]     n;
  dwcd_pkg::tok_t t0, t1;

  function automatic dwcd_pkg::tok_t mk(input logic [1:0] kind, input logic [5:0] code,
                                        input logic [7:0] value);
    dwcd_pkg::tok_t t;
    t.kind  = kind;
    t.code  = code;
    t.value = value;
    t.last  = 1'b0;
    return t;
  endfunction

  always_comb begin
    ctl_has        = 1'b1;
    ctl_tok        = '0;
    ctl_state      = ST_IDLE;
    ctl_ff_pending = ff_pending_r;
    unique case (byte_in)
      dwcd_pkg::B_FF: begin
        if (suppress_ff && ff_pending_r) begin
          ctl_has        = 1'b0;
          ctl_ff_pending = 1'b0;
        end else begin
          ctl_tok = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_FORM_FEED, 8'd0);
        end
      end
      dwcd_pkg::B_CR: ctl_tok = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_BEGIN_LINE, 8'd0);
      dwcd_pkg::B_LF: ctl_tok = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_LINE_FEED, 8'd0);
      dwcd_pkg::B_BS: ctl_tok = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_BACKSPACE, 8'd0);
      dwcd_pkg::B_ESC: begin
        ctl_has   = 1'b0;
        ctl_state = ST_ESC;
      end
      default: ctl_has = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    sel_nxt        = sel_r;
    ff_pending_nxt = ff_pending_r;
    n              = 2'd0;
    t0             = '0;
    t1             = '0;
    esc            = dwcd_pkg::esc_code(byte_in);
    if (byte_in != dwcd_pkg::B_NUL && byte_in != dwcd_pkg::B_DEL) begin
      unique case (state_r)
        ST_IDLE, ST_RUN: begin
          if (byte_in < dwcd_pkg::B_SPACE) begin
            state_nxt      = ctl_state;
            ff_pending_nxt = ctl_ff_pending;
            if (state_r == ST_RUN) begin
              // close the run first
              t0 = mk(dwcd_pkg::KIND_END, dwcd_pkg::CMD_FORM_FEED, 8'd0);
              t1 = ctl_tok;
              n  = ctl_has ? 2'd2 : 2'd1;
            end else begin
              t0 = ctl_tok;
              n  = ctl_has ? 2'd1 : 2'd0;
            end
          end else begin
            t0 = mk((state_r == ST_RUN) ? dwcd_pkg::KIND_CONT : dwcd_pkg::KIND_OPEN,
                    dwcd_pkg::CMD_FORM_FEED, byte_in);
            n         = 2'd1;
            state_nxt = ST_RUN;
          end
        end
        ST_ESC: begin
          state_nxt = ST_IDLE;
          if (dwcd_pkg::is_selector(byte_in)) begin
            sel_nxt   = byte_in;
            state_nxt = ST_ARG;
          end else if (esc[6]) begin
            n = 2'd1;
            if (esc[5:0] == dwcd_pkg::CMD_WHEEL_A2) begin
              t0 = mk(dwcd_pkg::KIND_CMD, esc[5:0], dwcd_pkg::WHEEL_A2);
            end else if (esc[5:0] == dwcd_pkg::CMD_WHEEL_A9) begin
              t0 = mk(dwcd_pkg::KIND_CMD, esc[5:0], dwcd_pkg::WHEEL_A9);
            end else begin
              t0 = mk(dwcd_pkg::KIND_CMD, esc[5:0], 8'd0);
            end
          end
        end
        ST_ARG: begin
          state_nxt = ST_IDLE;
          unique case (sel_r)
            dwcd_pkg::B_HT: begin
              n  = 2'd1;
              t0 = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_ABS_HTAB, byte_in);
            end
            dwcd_pkg::B_VT: begin
              n  = 2'd1;
              t0 = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_ABS_VTAB, byte_in);
            end
            dwcd_pkg::B_US: begin
              n  = 2'd1;
              t0 = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_SET_HMI, byte_in - 8'd1);
            end
            dwcd_pkg::B_RS: begin
              n  = 2'd1;
              t0 = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_SET_VMI, byte_in - 8'd1);
            end
            dwcd_pkg::B_FF: begin
              n  = 2'd1;
              t0 = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_CLEAR_TB, 8'd0);
            end
            dwcd_pkg::B_CR: begin
              if (byte_in == dwcd_pkg::B_P) begin
                n  = 2'd1;
                t0 = mk(dwcd_pkg::KIND_CMD, dwcd_pkg::CMD_REMOTE_RESET, 8'd0);
              end
            end
            default: n = 2'd0;
          endcase
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
    // mark the final token of this byte
    t0.last = (n == 2'd1);
    t1.last = (n == 2'd2);
    push.n    = n;
    push.tok0 = t0;
    push.tok1 = t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sel_r        <= 8'd0;
      ff_pending_r <= 1'b1;
    end else if (consume) begin
      state_r      <= state_nxt;
      sel_r        <= sel_nxt;
      ff_pending_r <= ff_pending_nxt;
    end
  end

  a_two_tok_shape: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> push.tok0.kind == dwcd_pkg::KIND_END &&
                       push.tok1.kind == dwcd_pkg::KIND_CMD && push.tok1.last)
    else $error("two-token beat has wrong shape");

  a_ff_pending_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !ff_pending_r |=> !ff_pending_r)
    else $error("first form feed flag came back");

  // nul and del leave the argument wait untouched
  a_arg_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    consume && state_r == ST_ARG && byte_in != dwcd_pkg::B_NUL &&
    byte_in != dwcd_pkg::B_DEL |=> state_r == ST_IDLE)
    else $error("argument byte did not return to idle");

endmodule

// ===== sv/dwcd_tok_buf.sv =====
module dwcd_tok_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  dwcd_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output dwcd_pkg::tok_t  head
);

  dwcd_pkg::tok_t                slot_r   [dwcd_pkg::BUF_DEPTH];
  dwcd_pkg::tok_t                slot_nxt [dwcd_pkg::BUF_DEPTH];
  logic [dwcd_pkg::CNT_W-1:0]    cnt_r, cnt_nxt, base;
  logic                          pop;

  assign out_valid = (cnt_r != '0);
  assign head      = slot_r[0];
  assign pop       = out_valid && out_ready;
  // room for a two-token beat, from the registered count only
  assign room      = (cnt_r <= dwcd_pkg::CNT_W'(dwcd_pkg::BUF_DEPTH - 2));

  always_comb begin
    base    = cnt_r - dwcd_pkg::CNT_W'(pop);
    cnt_nxt = base + dwcd_pkg::CNT_W'(push.n);
    for (int i = 0; i < dwcd_pkg::BUF_DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    // shift toward the head on a pop
    if (pop) begin
      for (int i = 0; i < dwcd_pkg::BUF_DEPTH - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
    end
    for (int i = 0; i < dwcd_pkg::BUF_DEPTH; i++) begin
      if (push.n != 2'd0 && base == dwcd_pkg::CNT_W'(i)) begin
        slot_nxt[i] = push.tok0;
      end
      if (push.n == 2'd2 && base + dwcd_pkg::CNT_W'(1) == dwcd_pkg::CNT_W'(i)) begin
        slot_nxt[i] = push.tok1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dwcd_pkg::CNT_W'(dwcd_pkg::BUF_DEPTH))
    else $error("token buffer overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("tokens pushed without room");

endmodule

// ===== sv/daisywheel_command_decoder_unit.sv =====
// Daisywheel command decoder: takes one byte of the printer command stream per
// in_ beat and produces zero, one or two token beats on out_ (an end-of-run
// token followed by a command when a control byte closes a text run).
// out_last_of_item marks the final token of each byte. An input byte sits in
// an input register and is decoded combinationally into a four-entry token
// buffer; a byte is taken from the input register whenever the buffer holds at
// most two tokens, so with out_ready high the block takes one byte per cycle
// and the output side sustains one token per cycle; bytes that give two tokens
// are limited by that one-token-per-cycle output. in_ready depends only on
// registered state. cfg_wr_data is the suppress-first-form-feed bit; write it
// only while idle.
module daisywheel_command_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  // byte input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  // token output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_token_kind,
  output logic [5:0] out_command_code,
  output logic [7:0] out_token_value,
  output logic       out_last_of_item,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic            byte_vld_r;
  logic [7:0]      byte_r;
  logic            suppress_ff_r;
  logic            room;
  logic            consume;
  dwcd_pkg::push_t push_raw, push_g;
  dwcd_pkg::tok_t  head;

  // the held byte moves on when the buffer has room for its worst case
  assign consume  = byte_vld_r && room;
  assign in_ready = !byte_vld_r || room;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_ready) begin
      byte_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      suppress_ff_r <= 1'b0;
    end else if (cfg_wr_en) begin
      suppress_ff_r <= cfg_wr_data;
    end
  end

  // decode and parse state
  dwcd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_in     (byte_r),
    .consume     (consume),
    .suppress_ff (suppress_ff_r),
    .push        (push_raw)
  );

  // only a byte that moves on pushes tokens
  always_comb begin
    push_g   = push_raw;
    push_g.n = consume ? push_raw.n : 2'd0;
  end

  // token buffer feeding the output
  dwcd_tok_buf u_tok_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_g),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_command_code = head.code;
  assign out_token_value  = head.value;
  assign out_last_of_item = head.last;

endmodule
